// ----- rtl/i128_pkg.sv -----
`default_nettype none
package i128_pkg;
  localparam int unsigned WordW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned SliceW = 16;
  localparam int unsigned NumSlices = WordW / SliceW;
  localparam int unsigned CntW = $clog2(WordW + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ITER,
    ST_FIX,
    ST_OUT
  } state_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ----- rtl/i128_cell.sv -----
`default_nettype none
// one 16-bit slice of the accumulator/remainder, operand and shift registers
module i128_cell (
  input  wire logic                         clk,
  input  wire i128_pkg::cell_ctrl_t         ctrl,
  input  wire logic [i128_pkg::SliceW-1:0]  load_x,
  input  wire logic [i128_pkg::SliceW-1:0]  load_y,
  input  wire logic                         add_en,
  input  wire logic                         carry_in,
  output logic                              carry_out,
  input  wire logic                         x_shin,
  output logic                              x_shout,
  input  wire logic                         r_shin,
  output logic                              r_shout,
  output logic [i128_pkg::SliceW-1:0]       acc_q,
  output logic [i128_pkg::SliceW-1:0]       x_q
);
  import i128_pkg::*;

  logic [SliceW-1:0] acc;
  logic [SliceW-1:0] x;
  logic [SliceW-1:0] y;
  logic [SliceW-1:0] acc_sh;
  logic [SliceW-1:0] addend;
  logic [SliceW:0]   sum;

  // divide: remainder shifts left taking the next dividend bit, then adds -den when add_en is set
  // multiply: accumulator adds the shifted multiplicand held in x when add_en is set
  assign acc_sh = ctrl.div_step ? {acc[SliceW-2:0], r_shin} : acc;
  assign addend = ctrl.div_step ? ~y : x;
  assign sum = {1'b0, acc_sh} + {1'b0, addend} + {{SliceW{1'b0}}, carry_in};
  assign carry_out = sum[SliceW];
  assign r_shout = acc[SliceW-1];
  assign x_shout = x[SliceW-1];
  assign acc_q = acc;
  assign x_q = x;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= '0;
      x <= load_x;
      y <= load_y;
    end else if (ctrl.mul_step) begin
      if (add_en) acc <= sum[SliceW-1:0];
      x <= {x[SliceW-2:0], x_shin};
    end else if (ctrl.div_step) begin
      acc <= add_en ? sum[SliceW-1:0] : acc_sh;
      x <= {x[SliceW-2:0], x_shin};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/i128_ctrl.sv -----
`default_nettype none
module i128_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_fire,
  input  wire logic                  out_fire,
  input  wire logic                  is_mul,
  input  wire logic                  trivial,
  output i128_pkg::state_t           state,
  output i128_pkg::cell_ctrl_t       ctrl,
  output logic [i128_pkg::CntW-1:0]  step
);
  import i128_pkg::*;

  state_t state_next;
  logic [CntW-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next = step;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_PREP;
      ST_PREP: begin
        step_next = '0;
        state_next = trivial ? ST_FIX : ST_ITER;
      end
      ST_ITER: begin
        step_next = step + 1'b1;
        if (step == CntW'(WordW - 1)) state_next = ST_FIX;
      end
      ST_FIX: state_next = ST_OUT;
      ST_OUT: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_PREP: ctrl.load = 1'b1;
      ST_ITER: begin
        ctrl.mul_step = is_mul;
        ctrl.div_step = !is_mul;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/int128_arith_unit.sv -----
// signed 128-bit arithmetic unit: add, subtract, multiply, divide
// s_axis: tdata carries operation, a_high, a_low, b_high, b_low; one transfer
// per item. m_axis: tdata carries result_high, result_low, divide_by_zero,
// a_less_than_b, a_equals_b; exactly one transfer per input transfer.
// one item is worked at a time; s_axis_tready is high only while idle.
// add and subtract go from input transfer through the load and fix-up states to
// output valid, as does divide by zero. multiply and divide step a chain of eight
// 16-bit cells one operand bit a cycle, with a ripple carry through the chain,
// plus operand load before and sign fix-up after.
// the result is held in an output register until m_axis_tready takes it,
// and the next item can be accepted in the cycle after that transfer.
// synchronous reset returns the sequencer to idle and drops m_axis_tvalid;
// an item in progress is lost.
`default_nettype none
module int128_arith_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // operation[1:0], a_high[65:2], a_low[129:66], b_high[193:130], b_low[257:194]
  input  wire logic [263:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_high[63:0], result_low[127:64], divide_by_zero[128],
  // a_less_than_b[129], a_equals_b[130]
  output logic [135:0]      m_axis_tdata
);
  import i128_pkg::*;

  state_t state;
  cell_ctrl_t ctrl;
  logic [CntW-1:0] step;
  logic in_fire, out_fire;

  op_t op;
  logic [WordW-1:0] a, b, ua, ub, mag_x, mag_y, res_mag, res;
  logic neg, dz, lt, eq;
  logic [WordW-1:0] acc_all, x_all;
  logic [NumSlices:0] carry, xsh, rsh;
  logic mul_bit, div_ge;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op <= op_t'(s_axis_tdata[1:0]);
      a <= {s_axis_tdata[65:2], s_axis_tdata[129:66]};
      b <= {s_axis_tdata[193:130], s_axis_tdata[257:194]};
    end
  end

  assign ua = a[WordW-1] ? (~a + 1'b1) : a;
  assign ub = b[WordW-1] ? (~b + 1'b1) : b;

  // multiply: x is the multiplicand shifted left, added when the multiplier bit is set
  // divide: x is the dividend shifted out msb first, y the divisor
  assign mag_x = ua;
  assign mag_y = ub;

  logic [WordW-1:0] mul_b;
  always_ff @(posedge clk) begin
    if (ctrl.load) mul_b <= ub;
    else if (ctrl.mul_step) mul_b <= {1'b0, mul_b[WordW-1:1]};
  end
  assign mul_bit = mul_b[0];

  // divide: carry out of the chain is set when shifted remainder >= divisor
  // (the remainder never exceeds 128 bits since it stays below the divisor)
  assign div_ge = carry[NumSlices] || rsh[NumSlices];
  assign carry[0] = (op == OP_DIV);
  assign xsh[0] = 1'b0;
  assign rsh[0] = x_all[WordW-1];

  genvar g;
  generate
    for (g = 0; g < NumSlices; g++) begin : g_cell
      cell_ctrl_t cc;
      assign cc = ctrl;
      i128_cell u_cell (
        .clk(clk),
        .ctrl(cc),
        .load_x(mag_x[g*SliceW +: SliceW]),
        .load_y(op == OP_MUL ? {SliceW{1'b0}} : mag_y[g*SliceW +: SliceW]),
        .add_en(op == OP_MUL ? mul_bit : div_ge),
        .carry_in(carry[g]),
        .carry_out(carry[g+1]),
        .x_shin(xsh[g]),
        .x_shout(xsh[g+1]),
        .r_shin(rsh[g]),
        .r_shout(rsh[g+1]),
        .acc_q(acc_all[g*SliceW +: SliceW]),
        .x_q(x_all[g*SliceW +: SliceW])
      );
    end
  endgenerate

  // quotient bits shift in from the lsb
  logic [WordW-1:0] quo;
  always_ff @(posedge clk) begin
    if (ctrl.load) quo <= '0;
    else if (ctrl.div_step) quo <= {quo[WordW-2:0], div_ge};
  end

  assign res_mag = (op == OP_MUL) ? acc_all : quo;
  assign neg = a[WordW-1] ^ b[WordW-1];

  always_ff @(posedge clk) begin
    if (state == ST_FIX) begin
      case (op)
        OP_ADD: res <= a + b;
        OP_SUB: res <= a - b;
        default: res <= dz ? '0 : (neg ? (~res_mag + 1'b1) : res_mag);
      endcase
      lt <= $signed(a) < $signed(b);
      eq <= (a == b);
    end
  end

  assign dz = (op == OP_DIV) && (b == '0);

  i128_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .out_fire(out_fire),
    .is_mul(op == OP_MUL),
    .trivial(op == OP_ADD || op == OP_SUB || dz),
    .state(state),
    .ctrl(ctrl),
    .step(step)
  );

  assign m_axis_tdata = {5'b0, eq, lt, dz, res[HalfW-1:0], res[WordW-1:HalfW]};

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_iter_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER) |-> (step < CntW'(WordW))) else $error("step overrun");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[128]) |-> (m_axis_tdata[127:0] == '0))
    else $error("divide by zero result not zero");
`endif
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i128_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned NumRandom = 1400;

  typedef struct packed {
    logic [63:0] b_low;
    logic [63:0] b_high;
    logic [63:0] a_low;
    logic [63:0] a_high;
    op_t         operation;
  } arith_req_t;

  typedef struct packed {
    logic        a_equals_b;
    logic        a_less_than_b;
    logic        divide_by_zero;
    logic [63:0] result_low;
    logic [63:0] result_high;
  } arith_rsp_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [263:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [135:0] m_axis_tdata;

  int unsigned src_idle_pct, sink_stall_pct;
  int unsigned fail_count;
  int unsigned cycle_count;
  arith_rsp_t expected_rsps[$];

  int128_arith_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [127:0] magnitude(logic [127:0] x);
    return x[127] ? (~x + 128'd1) : x;
  endfunction

  function automatic arith_rsp_t predict_arith(arith_req_t req);
    arith_rsp_t  rsp;
    logic [127:0] a, b, ma, mb, acc, rem, quo;
    logic        flip;
    a = {req.a_high, req.a_low};
    b = {req.b_high, req.b_low};
    ma = magnitude(a);
    mb = magnitude(b);
    flip = a[127] ^ b[127];
    rsp = '0;
    acc = '0;
    case (req.operation)
      OP_ADD: acc = a + b;
      OP_SUB: acc = a - b;
      OP_MUL: begin
        acc = ma * mb;
        if (flip) acc = ~acc + 128'd1;
      end
      default: begin
        if (b == '0) begin
          rsp.divide_by_zero = 1'b1;
        end else begin
          rem = '0;
          quo = '0;
          for (int i = 127; i >= 0; i--) begin
            rem = {rem[126:0], ma[i]};
            quo = {quo[126:0], 1'b0};
            if (rem >= mb) begin
              rem = rem - mb;
              quo[0] = 1'b1;
            end
          end
          acc = flip ? (~quo + 128'd1) : quo;
        end
      end
    endcase
    rsp.result_high = acc[127:64];
    rsp.result_low = acc[63:0];
    rsp.a_less_than_b = $signed(a) < $signed(b);
    rsp.a_equals_b = (a == b);
    return rsp;
  endfunction

  function automatic logic [63:0] rand_half();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      3: v = 64'h7fff_ffff_ffff_ffff;
      4: v = {$urandom} >> $urandom_range(0, 31);
      default: ;
    endcase
    return v;
  endfunction

  function automatic arith_req_t rand_req();
    arith_req_t r;
    r.operation = op_t'($urandom_range(0, 3));
    r.a_high = rand_half();
    r.a_low = rand_half();
    r.b_high = rand_half();
    r.b_low = rand_half();
    // keep operands small or sign-extended now and then, so quotients are not trivial
    if ($urandom_range(0, 3) == 0) r.b_high = {64{r.b_low[63]}};
    if ($urandom_range(0, 7) == 0) r.a_high = {64{r.a_low[63]}};
    if ($urandom_range(0, 15) == 0) {r.b_high, r.b_low} = {r.a_high, r.a_low};
    return r;
  endfunction

  // tvalid stays high after a transfer until the next call drives it
  task automatic send_req(arith_req_t req);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, req};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_rsps.insert(expected_rsps.size(), predict_arith(req));
  endtask

  // receiver: random stall, check each transfer against the oldest prediction
  always @(posedge clk) begin
    arith_rsp_t got, exp_rsp;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = arith_rsp_t'(m_axis_tdata[130:0]);
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transfer %h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got.result_high !== exp_rsp.result_high) begin
            $error("result_high expected %h actual %h", exp_rsp.result_high, got.result_high);
            fail_count++;
          end
          if (got.result_low !== exp_rsp.result_low) begin
            $error("result_low expected %h actual %h", exp_rsp.result_low, got.result_low);
            fail_count++;
          end
          if (got.divide_by_zero !== exp_rsp.divide_by_zero) begin
            $error("divide_by_zero expected %b actual %b",
                   exp_rsp.divide_by_zero, got.divide_by_zero);
            fail_count++;
          end
          if (got.a_less_than_b !== exp_rsp.a_less_than_b) begin
            $error("a_less_than_b expected %b actual %b",
                   exp_rsp.a_less_than_b, got.a_less_than_b);
            fail_count++;
          end
          if (got.a_equals_b !== exp_rsp.a_equals_b) begin
            $error("a_equals_b expected %b actual %b", exp_rsp.a_equals_b, got.a_equals_b);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    arith_req_t req;
    logic       known;
    arith_rsp_t rsp;
  } stim_row_t;

  localparam logic [63:0] Ones = '1;
  localparam logic [63:0] MinHi = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxHi = 64'h7fff_ffff_ffff_ffff;

  stim_row_t directed[$];

  task automatic add_row(op_t op, logic [63:0] ah, logic [63:0] al, logic [63:0] bh,
                         logic [63:0] bl, logic known = 1'b0, arith_rsp_t rsp = '0);
    stim_row_t row;
    row.req = '{b_low: bl, b_high: bh, a_low: al, a_high: ah, operation: op};
    row.known = known;
    row.rsp = rsp;
    directed.insert(directed.size(), row);
  endtask

  initial begin
    arith_rsp_t typed;
    fail_count = 0;
    cycle_count = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;

    add_row(OP_ADD, 0, 0, 0, 0, 1'b1, '{1'b1, 1'b0, 1'b0, 64'd0, 64'd0});
    add_row(OP_ADD, Ones, Ones, 0, 1, 1'b1, '{1'b0, 1'b1, 1'b0, 64'd0, 64'd0});
    add_row(OP_SUB, 0, 0, 0, 1, 1'b1, '{1'b0, 1'b1, 1'b0, Ones, Ones});
    add_row(OP_DIV, 0, 5, 0, 0, 1'b1, '{1'b0, 1'b0, 1'b1, 64'd0, 64'd0});
    add_row(OP_DIV, MinHi, 0, 0, 0, 1'b1, '{1'b0, 1'b1, 1'b1, 64'd0, 64'd0});
    // most negative divided by minus one wraps
    add_row(OP_DIV, MinHi, 0, Ones, Ones, 1'b1, '{1'b0, 1'b1, 1'b0, 64'd0, MinHi});
    add_row(OP_ADD, MaxHi, Ones, 0, 1);
    add_row(OP_SUB, MinHi, 0, 0, 1);
    add_row(OP_MUL, MinHi, 0, MinHi, 0);
    add_row(OP_MUL, MinHi, 0, Ones, Ones);
    add_row(OP_MUL, MaxHi, Ones, MaxHi, Ones);
    add_row(OP_MUL, Ones, Ones, 0, 7);
    add_row(OP_MUL, Ones, Ones, Ones, Ones);
    add_row(OP_MUL, 0, Ones, 0, Ones);
    add_row(OP_DIV, MaxHi, Ones, 0, 1);
    add_row(OP_DIV, Ones, 64'hffff_ffff_ffff_fff9, 0, 2);
    add_row(OP_DIV, 0, 7, Ones, 64'hffff_ffff_ffff_fffe);
    add_row(OP_DIV, 0, 3, 0, 10);
    add_row(OP_DIV, MinHi, 0, MinHi, 0);
    add_row(OP_DIV, Ones, Ones, MaxHi, Ones);
    add_row(OP_SUB, 5, 6, 5, 7);
    add_row(OP_ADD, MinHi, 0, MaxHi, Ones);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].known) begin
        typed = directed[i].rsp;
        if (predict_arith(directed[i].req) !== typed) begin
          $error("predictor disagrees with table row %0d", i);
          fail_count++;
        end
      end
      send_req(directed[i].req);
    end

    for (int n = 0; n < NumRandom; n++) begin
      case ((n * 5) / NumRandom)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        3: begin src_idle_pct = 6;  sink_stall_pct = 6;  end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      send_req(rand_req());
    end
    s_axis_tvalid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
